// ===== hdl/five_link_forward_kinematics_core_defines.svh =====
// ---------------------------------------------------------------------------
// five_link_forward_kinematics_core_defines
// assertion macros shared by the kinematics core
// ---------------------------------------------------------------------------
`ifndef FIVE_LINK_FORWARD_KINEMATICS_CORE_DEFINES_SVH
`define FIVE_LINK_FORWARD_KINEMATICS_CORE_DEFINES_SVH

// checked only outside reset
`define KF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// checked in every cycle, reset included
`define KF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== hdl/kf_pkg.sv =====
// ---------------------------------------------------------------------------
// kf_pkg
// types, constants and rounding helpers of the kinematics core
// ---------------------------------------------------------------------------
package kf_pkg;

  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int COORD_WIDTH_DEF = 18;
  localparam int ACC_W = 34;

  localparam logic [37:0] TURN_SCALE  = 38'd174992710548;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;

  // taylor divisors, sine chain then cosine chain
  localparam logic [6:0] STEP_DIV [2][4] = '{
    '{7'd72, 7'd42, 7'd20, 7'd6},
    '{7'd90, 7'd56, 7'd30, 7'd12}
  };
  localparam logic [29:0] STEP_MAG [2][4] = '{
    '{30'((64'd1 << 32) / 72), 30'((64'd1 << 32) / 42),
      30'((64'd1 << 32) / 20), 30'((64'd1 << 32) / 6)},
    '{30'((64'd1 << 32) / 90), 30'((64'd1 << 32) / 56),
      30'((64'd1 << 32) / 30), 30'((64'd1 << 32) / 12)}
  };

  localparam logic [15:0] UPPER_ARM_RST = 16'd8520;
  localparam logic [15:0] FOREARM_RST   = 16'd8258;
  localparam logic [15:0] TOOL_RST      = 16'd8126;
  localparam logic [14:0] TWIST_RST     = 15'd12345;
  localparam logic [14:0] OFFSET_RST    = 15'd11297;
  localparam logic [15:0] HEIGHT_RST    = 16'd10945;

  typedef enum logic [2:0] {
    REG_UPPER_ARM = 3'd0,
    REG_FOREARM   = 3'd1,
    REG_TOOL      = 3'd2,
    REG_TWIST     = 3'd3,
    REG_OFFSET    = 3'd4,
    REG_HEIGHT    = 3'd5
  } reg_idx_t;

  typedef logic signed [15:0] q14_t;
  typedef q14_t mat_t [3][3];
  typedef mat_t links_t [4];
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef acc_t vec_t [3];

  localparam q14_t ONE_Q14 = 16'sd16384;

  // round half away from zero, drop 14 fraction bits
  function automatic acc_t rnd14(input acc_t v);
    acc_t mag;
    mag = v[ACC_W-1] ? -v : v;
    mag = (mag + acc_t'(8192)) >>> 14;
    return v[ACC_W-1] ? -mag : mag;
  endfunction

  function automatic q14_t sat14(input acc_t v);
    q14_t r;
    if (v > acc_t'(16384)) begin
      r = ONE_Q14;
    end else if (v < -acc_t'(16384)) begin
      r = -ONE_Q14;
    end else begin
      r = q14_t'(v);
    end
    return r;
  endfunction

endpackage

// ===== hdl/kf_sincos.sv =====
// ---------------------------------------------------------------------------
// kf_sincos
// pipelined sine and cosine, taylor series by horner in q30
// ---------------------------------------------------------------------------
module kf_sincos #(
  parameter int ANGLE_WIDTH = kf_pkg::ANGLE_WIDTH_DEF,
  localparam int THETA_WIDTH = (ANGLE_WIDTH > 16 ? ANGLE_WIDTH : 16) + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [THETA_WIDTH-1:0] theta,
  output logic                          out_valid,
  output kf_pkg::q14_t                  sn,
  output kf_pkg::q14_t                  cs
);

  localparam int FRAC  = ANGLE_WIDTH - 3;
  localparam int NSTEP = 4;
  localparam int NS    = 3 * NSTEP + 1;

  logic [63:0] th64;
  logic [63:0] ph_prod;
  logic        v1;
  logic [31:0] ph1;
  logic        v2;
  logic [60:0] x_prod;
  logic [30:0] x2r;
  logic [1:0]  q2;
  logic [61:0] xx_prod;

  logic [NS-1:0] cv;
  logic [30:0]   cx  [NS];
  logic [31:0]   cx2 [NS];
  logic [1:0]    cq  [NS];

  logic [31:0] am [2][NSTEP];
  logic [31:0] bm [2][NSTEP];
  logic [29:0] bq [2][NSTEP];
  logic [30:0] tt [2][NSTEP];

  assign th64    = 64'(theta);
  assign ph_prod = th64 * {26'd0, kf_pkg::TURN_SCALE};
  assign x_prod  = 61'(ph1[29:0]) * 61'(kf_pkg::HALF_PI_Q30);
  assign xx_prod = 62'(x2r) * 62'(x2r);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      cv <= '0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      cv <= {cv[NS-2:0], v2};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph1    <= ph_prod[FRAC+8 +: 32];
      x2r    <= x_prod[60:30];
      q2     <= ph1[31:30];
      cx[0]  <= x2r;
      cx2[0] <= xx_prod[61:30];
      cq[0]  <= q2;
      for (int k = 1; k < NS; k++) begin
        cx[k]  <= cx[k-1];
        cx2[k] <= cx2[k-1];
        cq[k]  <= cq[k-1];
      end
    end
  end

  // each step: multiply by x^2, divide by a constant, subtract from one
  for (genvar c = 0; c < 2; c++) begin : g_chain
    for (genvar i = 0; i < NSTEP; i++) begin : g_step
      logic [30:0] t_in;
      logic [62:0] a_prod;
      logic [61:0] b_prod;
      logic [31:0] c_rem;
      logic [29:0] c_quo;
      if (i == 0) begin : g_first
        assign t_in = kf_pkg::ONE_Q30;
      end else begin : g_next
        assign t_in = tt[c][i-1];
      end
      assign a_prod = 63'(cx2[3*i]) * 63'(t_in);
      assign b_prod = 62'(am[c][i]) * 62'(kf_pkg::STEP_MAG[c][i]);
      assign c_rem  = bm[c][i] - 32'(bq[c][i]) * 32'(kf_pkg::STEP_DIV[c][i]);
      assign c_quo  = (c_rem >= 32'(kf_pkg::STEP_DIV[c][i])) ? bq[c][i] + 30'd1 : bq[c][i];
      always_ff @(posedge clk) begin
        if (en) begin
          am[c][i] <= a_prod[61:30];
          bm[c][i] <= am[c][i];
          bq[c][i] <= b_prod[61:32];
          tt[c][i] <= kf_pkg::ONE_Q30 - {1'b0, c_quo};
        end
      end
    end
  end

  // final multiply and clamp
  logic [61:0]        s_prod;
  logic [31:0]        s_val;
  logic [62:0]        c_prod;
  logic [31:0]        c_mul;
  logic signed [33:0] c_val;
  logic               fv;
  logic [30:0]        f_s;
  logic [30:0]        f_c;
  logic [1:0]         fq;

  assign s_prod = 62'(cx[NS-1]) * 62'(tt[0][NSTEP-1]);
  assign s_val  = s_prod[61:30];
  assign c_prod = 63'(cx2[NS-1]) * 63'(tt[1][NSTEP-1]);
  assign c_mul  = c_prod[61:30];
  assign c_val  = $signed({3'b000, kf_pkg::ONE_Q30}) - $signed({3'b000, c_mul[31:1]});

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (en) begin
      fv <= cv[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_s <= (s_val > 32'(kf_pkg::ONE_Q30)) ? kf_pkg::ONE_Q30 : s_val[30:0];
      if (c_val < 0) begin
        f_c <= '0;
      end else if (c_val > $signed({3'b000, kf_pkg::ONE_Q30})) begin
        f_c <= kf_pkg::ONE_Q30;
      end else begin
        f_c <= c_val[30:0];
      end
      fq <= cq[NS-1];
    end
  end

  // round to q14 and fold the quadrant in
  logic [31:0]  s_sum;
  logic [31:0]  c_sum;
  kf_pkg::q14_t s14;
  kf_pkg::q14_t c14;

  assign s_sum = 32'(f_s) + 32'd32768;
  assign c_sum = 32'(f_c) + 32'd32768;
  assign s14   = $signed(s_sum[31:16]);
  assign c14   = $signed(c_sum[31:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (fq)
        2'd0: begin
          sn <= s14;
          cs <= c14;
        end
        2'd1: begin
          sn <= c14;
          cs <= -s14;
        end
        2'd2: begin
          sn <= -s14;
          cs <= -c14;
        end
        default: begin
          sn <= -c14;
          cs <= s14;
        end
      endcase
    end
  end

endmodule

// ===== hdl/kf_link.sv =====
// ---------------------------------------------------------------------------
// kf_link
// builds the five dh link rotations from sines and cosines
// ---------------------------------------------------------------------------
module kf_link (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  kf_pkg::q14_t   sn [6],
  input  kf_pkg::q14_t   cs [6],
  output logic           out_valid,
  output kf_pkg::mat_t   m1,
  output kf_pkg::links_t links
);

  function automatic kf_pkg::mat_t link_mat(input kf_pkg::q14_t st, input kf_pkg::q14_t ct,
                                            input kf_pkg::q14_t sa, input kf_pkg::q14_t ca);
    kf_pkg::mat_t l;
    l[0][0] = ct;
    l[0][1] = -st;
    l[0][2] = '0;
    l[1][0] = kf_pkg::q14_t'(kf_pkg::rnd14(kf_pkg::acc_t'(st) * kf_pkg::acc_t'(ca)));
    l[1][1] = kf_pkg::q14_t'(kf_pkg::rnd14(kf_pkg::acc_t'(ct) * kf_pkg::acc_t'(ca)));
    l[1][2] = -sa;
    l[2][0] = kf_pkg::q14_t'(kf_pkg::rnd14(kf_pkg::acc_t'(st) * kf_pkg::acc_t'(sa)));
    l[2][1] = kf_pkg::q14_t'(kf_pkg::rnd14(kf_pkg::acc_t'(ct) * kf_pkg::acc_t'(sa)));
    l[2][2] = ca;
    return l;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // unit 4 holds the positive twist, unit 5 the negative one
  always_ff @(posedge clk) begin
    if (en) begin
      m1       <= link_mat(sn[0], cs[0], '0, kf_pkg::ONE_Q14);
      links[0] <= link_mat(sn[1], cs[1], sn[4], cs[4]);
      links[1] <= link_mat(sn[2], cs[2], '0, kf_pkg::ONE_Q14);
      links[2] <= link_mat(sn[3], cs[3], '0, kf_pkg::ONE_Q14);
      links[3] <= link_mat('0, kf_pkg::ONE_Q14, sn[5], cs[5]);
    end
  end

endmodule

// ===== hdl/kf_matstep.sv =====
// ---------------------------------------------------------------------------
// kf_matstep
// one link of the pose chain: rotation product and translation update
// ---------------------------------------------------------------------------
module kf_matstep (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  kf_pkg::mat_t   m,
  input  kf_pkg::mat_t   l,
  input  logic [15:0]    len,
  input  kf_pkg::vec_t   p,
  input  kf_pkg::links_t links,
  output logic           out_valid,
  output kf_pkg::mat_t   m_o,
  output kf_pkg::vec_t   p_o,
  output kf_pkg::links_t links_o
);

  logic           va;
  kf_pkg::acc_t   acc_a [3][3];
  kf_pkg::vec_t   pa;
  kf_pkg::links_t links_a;
  kf_pkg::acc_t   acc_n [3][3];
  kf_pkg::vec_t   pa_n;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        acc_n[r][c] = kf_pkg::acc_t'(m[r][0]) * kf_pkg::acc_t'(l[0][c])
                    + kf_pkg::acc_t'(m[r][1]) * kf_pkg::acc_t'(l[1][c])
                    + kf_pkg::acc_t'(m[r][2]) * kf_pkg::acc_t'(l[2][c]);
      end
      // translation uses the first column before this link
      pa_n[r] = p[r] + kf_pkg::acc_t'(m[r][0]) * kf_pkg::acc_t'({1'b0, len});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_a   <= acc_n;
      pa      <= pa_n;
      links_a <= links;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          m_o[r][c] <= kf_pkg::sat14(kf_pkg::rnd14(acc_a[r][c]));
        end
      end
      p_o     <= pa;
      links_o <= links_a;
    end
  end

endmodule

// ===== hdl/five_link_forward_kinematics_core.sv =====
// ---------------------------------------------------------------------------
// five_link_forward_kinematics_core
// end-effector pose of a five-link dh arm from four joint angles
// ---------------------------------------------------------------------------
// One joint vector is taken per clock unless the output stalls. Stages:
// one maps raw angles to dh angles, 17 evaluate six sine/cosine pairs
// (four multiply stages of the horner chain are the long pole), one
// builds the link matrices, eight chain four matrix products, and one
// rounds and saturates the translation. A stall on the output freezes
// the whole pipeline, so s_tready follows m_tready whenever a result is
// waiting. The user must write configuration over the apb port only
// while no transaction is in flight; the block does not enforce this.
// Registers sit at byte addresses 0x00 to 0x14.
// ---------------------------------------------------------------------------
`include "five_link_forward_kinematics_core_defines.svh"

module five_link_forward_kinematics_core #(
  parameter int ANGLE_WIDTH = kf_pkg::ANGLE_WIDTH_DEF,
  parameter int COORD_WIDTH = kf_pkg::COORD_WIDTH_DEF,
  localparam int IN_W  = ((4 * ANGLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((144 + 3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // input transaction
  input  logic             s_tvalid,
  output logic             s_tready,
  // base_angle, shoulder_angle, elbow_angle, wrist_angle
  input  logic [IN_W-1:0]  s_tdata,
  // result transaction
  output logic             m_tvalid,
  input  logic             m_tready,
  // rot_00 .. rot_22 row major, pos_x, pos_y, pos_z
  output logic [OUT_W-1:0] m_tdata,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = ANGLE_WIDTH;
  localparam int TW = (ANGLE_WIDTH > 16 ? ANGLE_WIDTH : 16) + 2;
  localparam kf_pkg::acc_t CMAX = kf_pkg::acc_t'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam kf_pkg::acc_t CMIN = -CMAX - kf_pkg::acc_t'(1);

  // configuration registers
  logic [15:0] upper_arm_length;
  logic [15:0] forearm_length;
  logic [15:0] tool_length;
  logic [14:0] twist_angle;
  logic [14:0] joint_offset;
  logic [15:0] height_offset;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_arm_length <= kf_pkg::UPPER_ARM_RST;
      forearm_length   <= kf_pkg::FOREARM_RST;
      tool_length      <= kf_pkg::TOOL_RST;
      twist_angle      <= kf_pkg::TWIST_RST;
      joint_offset     <= kf_pkg::OFFSET_RST;
      height_offset    <= kf_pkg::HEIGHT_RST;
    end else if (cfg_write) begin
      case (paddr[4:2])
        kf_pkg::REG_UPPER_ARM: upper_arm_length <= pwdata[15:0];
        kf_pkg::REG_FOREARM:   forearm_length   <= pwdata[15:0];
        kf_pkg::REG_TOOL:      tool_length      <= pwdata[15:0];
        kf_pkg::REG_TWIST:     twist_angle      <= pwdata[14:0];
        kf_pkg::REG_OFFSET:    joint_offset     <= pwdata[14:0];
        kf_pkg::REG_HEIGHT:    height_offset    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      kf_pkg::REG_UPPER_ARM: prdata = {16'd0, upper_arm_length};
      kf_pkg::REG_FOREARM:   prdata = {16'd0, forearm_length};
      kf_pkg::REG_TOOL:      prdata = {16'd0, tool_length};
      kf_pkg::REG_TWIST:     prdata = {17'd0, twist_angle};
      kf_pkg::REG_OFFSET:    prdata = {17'd0, joint_offset};
      kf_pkg::REG_HEIGHT:    prdata = {16'd0, height_offset};
      default:               prdata = '0;
    endcase
  end

  // whole pipeline moves together; it only holds when a result waits
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // dh angle map; units 4 and 5 carry the plus and minus link twist
  logic signed [TW-1:0] theta_next [6];
  logic signed [TW-1:0] theta [6];
  logic signed [TW-1:0] off_ext;
  logic signed [TW-1:0] twist_ext;
  logic                 map_valid;

  assign off_ext   = TW'($signed({1'b0, joint_offset}));
  assign twist_ext = TW'($signed({1'b0, twist_angle}));

  always_comb begin
    theta_next[0] = TW'($signed(s_tdata[AW-1:0]));
    theta_next[1] = off_ext - TW'($signed(s_tdata[2*AW-1:AW]));
    theta_next[2] = -TW'($signed(s_tdata[3*AW-1:2*AW])) - off_ext;
    theta_next[3] = -TW'($signed(s_tdata[4*AW-1:3*AW]));
    theta_next[4] = twist_ext;
    theta_next[5] = -twist_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= 1'b0;
    end else if (adv) begin
      map_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      theta <= theta_next;
    end
  end

  // six sine/cosine pipelines in lock step
  logic [5:0]   sc_valid;
  kf_pkg::q14_t sc_sin [6];
  kf_pkg::q14_t sc_cos [6];

  for (genvar g = 0; g < 6; g++) begin : g_sc
    kf_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sincos (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (map_valid),
      .theta     (theta[g]),
      .out_valid (sc_valid[g]),
      .sn        (sc_sin[g]),
      .cs        (sc_cos[g])
    );
  end

  // link matrices; the first link is the chain's starting rotation
  logic [4:0]     st_valid;
  kf_pkg::mat_t   st_m [5];
  kf_pkg::vec_t   st_p [5];
  kf_pkg::links_t st_links [5];
  logic [15:0]    step_len [4];

  kf_link u_link (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (sc_valid[0]),
    .sn        (sc_sin),
    .cs        (sc_cos),
    .out_valid (st_valid[0]),
    .m1        (st_m[0]),
    .links     (st_links[0])
  );

  assign st_p[0]     = '{default: '0};
  assign step_len[0] = '0;
  assign step_len[1] = upper_arm_length;
  assign step_len[2] = forearm_length;
  assign step_len[3] = tool_length;

  for (genvar k = 0; k < 4; k++) begin : g_step
    kf_matstep u_matstep (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (st_valid[k]),
      .m         (st_m[k]),
      .l         (st_links[k][k]),
      .len       (step_len[k]),
      .p         (st_p[k]),
      .links     (st_links[k]),
      .out_valid (st_valid[k+1]),
      .m_o       (st_m[k+1]),
      .p_o       (st_p[k+1]),
      .links_o   (st_links[k+1])
    );
  end

  // translation rounding, height offset and saturation
  kf_pkg::acc_t           pos_v [3];
  logic [COORD_WIDTH-1:0] pos_next [3];
  logic [COORD_WIDTH-1:0] pos_q [3];
  kf_pkg::q14_t           rot_q [9];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      pos_v[r] = kf_pkg::rnd14(st_p[4][r]);
      if (r == 2) begin
        pos_v[r] = pos_v[r] + kf_pkg::acc_t'({1'b0, height_offset});
      end
      if (pos_v[r] > CMAX) begin
        pos_next[r] = CMAX[COORD_WIDTH-1:0];
      end else if (pos_v[r] < CMIN) begin
        pos_next[r] = CMIN[COORD_WIDTH-1:0];
      end else begin
        pos_next[r] = pos_v[r][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= st_valid[4];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          rot_q[3*r+c] <= st_m[4][r][c];
        end
      end
      pos_q <= pos_next;
    end
  end

  always_comb begin
    m_tdata = '0;
    for (int i = 0; i < 9; i++) begin
      m_tdata[16*i +: 16] = rot_q[i];
    end
    for (int i = 0; i < 3; i++) begin
      m_tdata[144 + COORD_WIDTH*i +: COORD_WIDTH] = pos_q[i];
    end
  end

  // the six trig pipelines must never drift apart
  `KF_ASSERT(sc_lock_step, sc_valid == 6'b000000 || sc_valid == 6'b111111, "trig units out of step")
  // a held output freezes every stage of the chain
  `KF_ASSERT(stall_freezes_chain, !s_tready |=> $stable(st_valid), "chain moved during stall")
  // saturation keeps the first rotation entry inside one in q14
  `KF_ASSERT(rot_in_range, m_tvalid |-> ($signed(m_tdata[15:0]) <= 16384 && $signed(m_tdata[15:0]) >= -16384), "rotation entry out of range")
  `KF_ASSERT_RST(reset_clears_out, rst |=> !m_tvalid, "result valid after reset")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// checks the five-link kinematics core against a bit-exact pose predictor,
// with random gaps on both stream sides and register changes between phases
// ---------------------------------------------------------------------------
module testbench;

  localparam int AW = 16;
  localparam int CW = 18;
  localparam int IN_W = 64;
  localparam int OUT_W = 200;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  localparam longint TURN_K = 64'd174992710548;
  localparam longint HALF_PI_K = 64'd1686629713;
  localparam longint ONE30 = 64'd1073741824;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  five_link_forward_kinematics_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor copy of the registers
  longint arm_len, fore_len, tool_len, twist, offs, height;

  logic [OUT_W-1:0] pose_queue[$];
  int mismatches = 0;
  int poses_seen = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  function automatic longint trunc_div(longint a, longint b);
    return a / b;
  endfunction

  function automatic longint round_away(longint v);
    if (v >= 0) return (v + 8192) >>> 14;
    return -((-v + 8192) >>> 14);
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // q14 sine and cosine through a 32-bit phase and taylor series
  task automatic trig_q14(input longint theta, output longint sn, output longint cs);
    logic [63:0] prod;
    logic [31:0] ph;
    logic [1:0] quad;
    longint x, x2, t, u, s14, c14;
    prod = 64'(theta) * 64'(TURN_K);
    ph = prod[AW+36:AW+5];
    quad = ph[31:30];
    x = (longint'({34'd0, ph[29:0]}) * HALF_PI_K) >>> 30;
    x2 = trunc_div(x * x, ONE30);
    t = ONE30 - x2 / 72;
    t = ONE30 - trunc_div(x2 * t, ONE30) / 42;
    t = ONE30 - trunc_div(x2 * t, ONE30) / 20;
    t = ONE30 - trunc_div(x2 * t, ONE30) / 6;
    t = clampl(trunc_div(x * t, ONE30), 0, ONE30);
    u = ONE30 - x2 / 90;
    u = ONE30 - trunc_div(x2 * u, ONE30) / 56;
    u = ONE30 - trunc_div(x2 * u, ONE30) / 30;
    u = ONE30 - trunc_div(x2 * u, ONE30) / 12;
    u = clampl(ONE30 - trunc_div(x2 * u, ONE30) / 2, 0, ONE30);
    s14 = (t + 32768) >>> 16;
    c14 = (u + 32768) >>> 16;
    case (quad)
      2'd0: begin sn = s14; cs = c14; end
      2'd1: begin sn = c14; cs = -s14; end
      2'd2: begin sn = -s14; cs = -c14; end
      default: begin sn = -c14; cs = s14; end
    endcase
  endtask

  task automatic predict_pose(input logic [IN_W-1:0] joints, output logic [OUT_W-1:0] pose);
    longint th[5], al[5], ln[5];
    longint m[3][3], nm[3][3], lk[3][3], p[3];
    longint st, ct, sa, ca, acc, v;
    longint cmax;
    cmax = (64'sd1 <<< (CW - 1)) - 1;
    th[0] = longint'($signed(joints[15:0]));
    th[1] = offs - longint'($signed(joints[31:16]));
    th[2] = -longint'($signed(joints[47:32])) - offs;
    th[3] = -longint'($signed(joints[63:48]));
    th[4] = 0;
    al = '{0, twist, 0, 0, -twist};
    ln = '{0, 0, arm_len, fore_len, tool_len};
    for (int r = 0; r < 3; r++) begin
      p[r] = 0;
      for (int c = 0; c < 3; c++) m[r][c] = (r == c) ? 16384 : 0;
    end
    for (int i = 0; i < 5; i++) begin
      trig_q14(th[i], st, ct);
      trig_q14(al[i], sa, ca);
      for (int r = 0; r < 3; r++) p[r] += m[r][0] * ln[i];
      lk[0][0] = ct; lk[0][1] = -st; lk[0][2] = 0;
      lk[1][0] = round_away(st * ca); lk[1][1] = round_away(ct * ca); lk[1][2] = -sa;
      lk[2][0] = round_away(st * sa); lk[2][1] = round_away(ct * sa); lk[2][2] = ca;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += m[r][k] * lk[k][c];
          nm[r][c] = clampl(round_away(acc), -16384, 16384);
        end
      m = nm;
    end
    pose = '0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) pose[(r * 3 + c) * 16 +: 16] = 16'(m[r][c]);
    for (int r = 0; r < 3; r++) begin
      v = round_away(p[r]);
      if (r == 2) v += height;
      v = clampl(v, -cmax - 1, cmax);
      pose[144 + r * CW +: CW] = CW'(v);
    end
  endtask

  // one joint vector; a random gap first, valid stays up between
  // back-to-back transactions
  task automatic send_joints(input logic [IN_W-1:0] joints);
    logic [OUT_W-1:0] pose;
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_pose(joints, pose);
    pose_queue = {pose_queue, pose};
    s_tvalid <= 1'b1;
    s_tdata <= joints;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_angles(input int b, input int s, input int e, input int w);
    send_joints({16'(w), 16'(e), 16'(s), 16'(b)});
  endtask

  // apb write: setup then access; the bus is released by the caller
  task automatic write_reg(input kf_pkg::reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      kf_pkg::REG_UPPER_ARM: arm_len = val[15:0];
      kf_pkg::REG_FOREARM: fore_len = val[15:0];
      kf_pkg::REG_TOOL: tool_len = val[15:0];
      kf_pkg::REG_TWIST: twist = val[14:0];
      kf_pkg::REG_OFFSET: offs = val[14:0];
      kf_pkg::REG_HEIGHT: height = val[15:0];
      default: ;
    endcase
  endtask

  // idle point: all poses back, then let the pipeline empty
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pose_queue.size() != 0 && !timed_out) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_geometry(input int a, input int f, input int t, input int tw,
                               input int o, input int h);
    wait_idle();
    write_reg(kf_pkg::REG_UPPER_ARM, a);
    write_reg(kf_pkg::REG_FOREARM, f);
    write_reg(kf_pkg::REG_TOOL, t);
    write_reg(kf_pkg::REG_TWIST, tw);
    write_reg(kf_pkg::REG_OFFSET, o);
    write_reg(kf_pkg::REG_HEIGHT, h);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // extremes of every angle, wrap around, zero
  task automatic test_directed_angles();
    send_angles(0, 0, 0, 0);
    send_angles(-32768, -32768, -32768, -32768);
    send_angles(32767, 32767, 32767, 32767);
    send_angles(32767, -32768, 32767, -32768);
    send_angles(12868, 0, 0, 0);
    send_angles(-12868, 25736, -25736, 6434);
    send_angles(25736, 12868, 6434, -6434);
    send_angles(1, -1, 1, -1);
    send_angles(0, 11297, -11297, 0);
    send_angles(-1, 32767, -32768, 1);
  endtask

  // maximum lengths drive the translation into saturation, zero geometry at the end
  task automatic test_saturation();
    load_geometry(65535, 65535, 65535, 0, 0, 65535);
    send_angles(0, 0, 0, 0);
    send_angles(0, 0, 25736, 0);
    send_angles(0, 12868, 0, 0);
    send_angles(25736, 25736, 0, 0);
    load_geometry(65535, 65535, 65535, 25736, 25736, 0);
    send_angles(0, 0, 0, 0);
    send_angles(-32768, 32767, 0, 12868);
    load_geometry(0, 0, 0, 0, 0, 0);
    send_angles(0, 0, 0, 0);
    send_angles(32767, -32768, 32767, 32767);
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++)
      send_joints({$urandom(), $urandom()});
  endtask

  task automatic test_random_geometry();
    load_geometry(8520, 8258, 8126, 12345, 11297, 10945);
    run_random(300);
    for (int ph = 0; ph < 4; ph++) begin
      load_geometry($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 25736),
                    $urandom_range(0, 25736), $urandom_range(0, 65535));
      run_random(200);
    end
  endtask

  // result side: random stall per transaction, compare with oldest prediction
  initial begin
    int stall;
    logic [OUT_W-1:0] want;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 4);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      poses_seen++;
      if (pose_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose %h", m_tdata);
      end else begin
        want = pose_queue.pop_front();
        if (want !== m_tdata) begin
          mismatches++;
          if (mismatches <= 10)
            for (int f = 0; f < 12; f++)
              if (f < 9 ? want[f*16 +: 16] !== m_tdata[f*16 +: 16]
                        : want[144+(f-9)*CW +: CW] !== m_tdata[144+(f-9)*CW +: CW])
                $display("pose %0d field %0d: expected %h actual %h", poses_seen, f,
                         f < 9 ? 32'(want[f*16 +: 16]) : 32'(want[144+(f-9)*CW +: CW]),
                         f < 9 ? 32'(m_tdata[f*16 +: 16])
                               : 32'(m_tdata[144+(f-9)*CW +: CW]));
        end
      end
    end
  end

  // watchdog over cycles with no transaction on either stream
  initial begin
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1;
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    arm_len = 8520; fore_len = 8258; tool_len = 8126;
    twist = 12345; offs = 11297; height = 10945;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_angles();
    test_saturation();
    test_random_geometry();
    wait_idle();
    $display("sent %0d joint vectors, checked %0d poses over 9 register settings",
             items_sent, poses_seen);
    if (mismatches == 0 && pose_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d poses missing", mismatches, pose_queue.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
